// ----- sv/vro_pkg.sv -----
// ----------------------------------------------------------------------------
// vro_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package vro_pkg;

  localparam int GRID_SIZE = 32;
  localparam int FRAC_BITS = 8;
  localparam int GRID_W    = $clog2(GRID_SIZE);
  localparam int CELL_CNT  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W    = 3 * GRID_W;
  localparam int POS_W     = 13;
  localparam int CELL_W    = 5;
  localparam int CUR_W     = 10;
  localparam int NUM_W     = FRAC_BITS + 17;
  localparam int ITER_W    = $clog2(NUM_W);
  localparam int T_W       = 34;
  localparam int DSQ_W     = 2 * POS_W + 2;
  localparam int OCC_W     = 9;
  localparam int CNT_W     = 8;

  typedef enum logic [1:0] {
    REG_MAX_STEPS,
    REG_PER_BLOCK,
    REG_MIN_DIST_SQ,
    REG_OCC_EN
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQUARE,
    ST_DECIDE,
    ST_DIVIDE,
    ST_CHECK,
    ST_STEP,
    ST_READ,
    ST_COUNT
  } state_e;

  typedef struct packed {
    logic clear;
    logic wr_cell;
    logic cap;
    logic sq;
    logic div_init;
    logic div_run;
    logic step;
    logic rd;
    logic cnt;
    logic fin_open;
    logic fin_walk;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic sq_last;
    logic open_air;
    logic div_last;
    logic walk_end;
    logic at_end;
  } sts_t;

endpackage

// ----- sv/vro_ctrl.sv -----
// ----------------------------------------------------------------------------
// vro_ctrl
// sequencer for map clearing, cell writes, the distance check, setup divisions and the voxel walk
// ----------------------------------------------------------------------------
module vro_ctrl import vro_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic kind_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (kind_i) begin
            cmd_o.cap = 1'b1;
            state_d   = ST_SQUARE;
          end else begin
            cmd_o.wr_cell = 1'b1;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.sq = 1'b1;
        if (sts_i.sq_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.open_air) begin
          cmd_o.fin_open = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.walk_end) begin
          cmd_o.fin_walk = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        if (sts_i.at_end) begin
          cmd_o.fin_walk = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.cnt = 1'b1;
        state_d   = ST_CHECK;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- sv/vro_dp.sv -----
// ----------------------------------------------------------------------------
// vro_dp
// occupancy map, distance check, shared divider and dda walk registers
// ----------------------------------------------------------------------------
module vro_dp import vro_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [POS_W-1:0]     lis_i [3],
  input  logic [POS_W-1:0]     src_i [3],
  input  logic [CELL_W-1:0]    cell_i [3],
  input  logic                 cell_solid_i,
  input  logic                 cfg_we_i,
  input  cfg_reg_e             cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 done_o,
  output logic [OCC_W-1:0]     occlusion_o,
  output logic [CNT_W-1:0]     solid_count_o,
  output logic                 reached_source_o
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [T_W-1:0]     T_NEVER = '1;

  // configuration
  logic [7:0]  max_steps_q;
  logic [8:0]  per_block_q;
  logic [15:0] min_dist_sq_q;
  logic        occ_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steps_q   <= 8'd64;
      per_block_q   <= 9'd87;
      min_dist_sq_q <= '0;
      occ_en_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_STEPS:   max_steps_q   <= cfg_data_i[7:0];
        REG_PER_BLOCK:   per_block_q   <= cfg_data_i[8:0];
        REG_MIN_DIST_SQ: min_dist_sq_q <= cfg_data_i;
        REG_OCC_EN:      occ_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // occupancy map
  logic              mem_q [CELL_CNT];
  logic [ADDR_W-1:0] clr_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic              rd_q;
  logic              in_grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign mem_we    = cmd_i.clear | cmd_i.wr_cell;
  assign mem_waddr = cmd_i.clear ? clr_q :
                     {cell_i[2][GRID_W-1:0], cell_i[1][GRID_W-1:0], cell_i[0][GRID_W-1:0]};
  assign mem_wdata = cmd_i.clear ? 1'b0 : cell_solid_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[mem_raddr];
  end

  // query registers
  logic [POS_W-1:0]        lp_q [3];
  logic [POS_W-1:0]        ad_q [3];
  logic                    dir_q [3];
  logic signed [CUR_W-1:0] cur_q [3];
  logic signed [CUR_W-1:0] end_q [3];
  logic [T_W-1:0]          tmax_q [3];
  logic [T_W-1:0]          tdel_q [3];
  logic [1:0]              sq_idx_q;
  logic [DSQ_W-1:0]        dsq_q;
  logic [2:0]              div_j_q;
  logic [ITER_W-1:0]       iter_q;
  logic [NUM_W-1:0]        num_q;
  logic [POS_W-1:0]        rem_q;
  logic [CNT_W-1:0]        n_q;
  logic [CNT_W-1:0]        count_q;

  function automatic logic [NUM_W-1:0] numer(input logic [2:0] j,
                                             input logic [POS_W-1:0] lp,
                                             input logic dir);
    logic [FRAC_BITS:0] frac;
    logic [FRAC_BITS:0] bnd;
    frac = {1'b0, lp[FRAC_BITS-1:0]};
    bnd  = dir ? ONE - frac : frac;
    if (j[0]) numer = NUM_W'(ONE) << 16;
    else      numer = {bnd, 16'b0};
  endfunction

  // squared distance, one axis per cycle
  logic [POS_W-1:0]   sq_ad;
  logic [2*POS_W-1:0] sq_val;
  assign sq_ad  = ad_q[sq_idx_q];
  assign sq_val = sq_ad * sq_ad;

  // restoring divider, one quotient bit per cycle
  logic [1:0]       div_k;
  logic [POS_W:0]   rem_sh;
  logic             q_bit;
  logic [POS_W:0]   rem_sub;
  logic [NUM_W-1:0] num_n;
  logic [T_W-1:0]   q_val;
  logic [2:0]       div_jn;
  logic [1:0]       div_kn;

  assign div_k   = div_j_q[2:1];
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, ad_q[div_k]};
  assign rem_sub = rem_sh - {1'b0, ad_q[div_k]};
  assign num_n   = {num_q[NUM_W-2:0], q_bit};
  assign q_val   = (ad_q[div_k] == '0) ? T_NEVER : T_W'(num_n);
  assign div_jn  = div_j_q + 3'd1;
  assign div_kn  = (div_jn < 3'd6) ? div_jn[2:1] : 2'd0;

  // walk axis choice
  logic                    at_end;
  logic [1:0]              ax;
  logic signed [CUR_W-1:0] cur_nx;
  logic                    cur_in;

  assign at_end = (cur_q[0] == end_q[0]) && (cur_q[1] == end_q[1]) && (cur_q[2] == end_q[2]);

  always_comb begin
    if (tmax_q[0] <= tmax_q[1] && tmax_q[0] <= tmax_q[2]) ax = 2'd0;
    else if (tmax_q[1] <= tmax_q[2])                        ax = 2'd1;
    else                                                    ax = 2'd2;
  end

  assign cur_nx    = dir_q[ax] ? cur_q[ax] + CUR_W'(1) : cur_q[ax] - CUR_W'(1);
  assign cur_in    = (cur_q[0][CUR_W-1:GRID_W] == '0) && (cur_q[1][CUR_W-1:GRID_W] == '0) &&
                     (cur_q[2][CUR_W-1:GRID_W] == '0);
  assign mem_raddr = {cur_q[2][GRID_W-1:0], cur_q[1][GRID_W-1:0], cur_q[0][GRID_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      for (int k = 0; k < 3; k++) begin
        lp_q[k]  <= lis_i[k];
        dir_q[k] <= src_i[k] > lis_i[k];
        ad_q[k]  <= (src_i[k] > lis_i[k]) ? src_i[k] - lis_i[k] : lis_i[k] - src_i[k];
        cur_q[k] <= CUR_W'(lis_i[k][POS_W-1:FRAC_BITS]);
        end_q[k] <= CUR_W'(src_i[k][POS_W-1:FRAC_BITS]);
      end
      dsq_q    <= '0;
      sq_idx_q <= '0;
    end
    if (cmd_i.sq) begin
      dsq_q    <= dsq_q + DSQ_W'(sq_val);
      sq_idx_q <= sq_idx_q + 2'd1;
    end
    if (cmd_i.div_init) begin
      div_j_q <= '0;
      iter_q  <= '0;
      rem_q   <= '0;
      num_q   <= numer(3'd0, lp_q[0], dir_q[0]);
      n_q     <= '0;
      count_q <= '0;
    end
    if (cmd_i.div_run) begin
      if (iter_q == ITER_W'(NUM_W - 1)) begin
        if (div_j_q[0]) tdel_q[div_k] <= q_val;
        else            tmax_q[div_k] <= q_val;
        div_j_q <= div_jn;
        iter_q  <= '0;
        rem_q   <= '0;
        num_q   <= numer(div_jn, lp_q[div_kn], dir_q[div_kn]);
      end else begin
        iter_q <= iter_q + 1'b1;
        rem_q  <= q_bit ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
        num_q  <= num_n;
      end
    end
    if (cmd_i.step && ad_q[ax] != '0) begin
      cur_q[ax]  <= cur_nx;
      tmax_q[ax] <= tmax_q[ax] + tdel_q[ax];
    end
    if (cmd_i.rd) in_grid_q <= cur_in;
    if (cmd_i.cnt) begin
      n_q <= n_q + 1'b1;
      if (rd_q && in_grid_q) count_q <= count_q + 1'b1;
    end
  end

  assign sts_o.clear_last = clr_q == ADDR_W'(CELL_CNT - 1);
  assign sts_o.sq_last    = sq_idx_q == 2'd2;
  assign sts_o.open_air   = !occ_en_q || (dsq_q < DSQ_W'(min_dist_sq_q));
  assign sts_o.div_last   = (div_j_q == 3'd5) && (iter_q == ITER_W'(NUM_W - 1));
  assign sts_o.walk_end   = at_end || (n_q >= max_steps_q);
  assign sts_o.at_end     = at_end;

  // result registers
  logic [CNT_W+8:0] prod;
  assign prod = count_q * per_block_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.fin_open | cmd_i.fin_walk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_open) begin
      occlusion_o      <= '0;
      solid_count_o    <= '0;
      reached_source_o <= 1'b1;
    end else if (cmd_i.fin_walk) begin
      occlusion_o      <= (prod > (CNT_W+9)'(256)) ? OCC_W'(256) : prod[OCC_W-1:0];
      solid_count_o    <= count_q;
      reached_source_o <= at_end;
    end
  end

endmodule

// ----- sv/voxel_ray_occlusion_unit.sv -----
// ----------------------------------------------------------------------------
// voxel_ray_occlusion_unit
// occupancy map with a dda ray walk giving sound occlusion between two points
// ----------------------------------------------------------------------------
// an item is taken on a clock edge with start_i high and busy_o low.
// kind_i low writes one map cell: it completes at that edge, gives no result
// and busy_o stays low. kind_i high starts a query; busy_o stays high until the
// result, which shows for exactly one cycle with done_o high. the receiver
// cannot stall, so results are never held.
// a query runs a distance check, then setup (six 25-bit divisions on one
// shared radix-2 divider), then for each cell step the states check (walk
// end), step (axis choice), read (map read into a register) and count, in
// that order; open-air answers skip the divisions and the walk.
// the map is one single-port-write bit memory with a registered read port.
// after reset the block clears the map, one cell per cycle, all 32768 cells,
// with busy_o high; configuration writes are taken at any time
// (cfg_ready_o is always high) and belong in idle periods.
// ----------------------------------------------------------------------------
module voxel_ray_occlusion_unit import vro_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              kind_i,
  input  logic [POS_W-1:0]  listener_x_i,
  input  logic [POS_W-1:0]  listener_y_i,
  input  logic [POS_W-1:0]  listener_z_i,
  input  logic [POS_W-1:0]  source_x_i,
  input  logic [POS_W-1:0]  source_y_i,
  input  logic [POS_W-1:0]  source_z_i,
  input  logic [CELL_W-1:0] cell_x_i,
  input  logic [CELL_W-1:0] cell_y_i,
  input  logic [CELL_W-1:0] cell_z_i,
  input  logic              cell_solid_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              done_o,
  output logic [OCC_W-1:0]  occlusion_o,
  output logic [CNT_W-1:0]  solid_count_o,
  output logic              reached_source_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [POS_W-1:0]  lis [3];
  logic [POS_W-1:0]  src [3];
  logic [CELL_W-1:0] cidx [3];

  assign lis[0]  = listener_x_i;
  assign lis[1]  = listener_y_i;
  assign lis[2]  = listener_z_i;
  assign src[0]  = source_x_i;
  assign src[1]  = source_y_i;
  assign src[2]  = source_z_i;
  assign cidx[0] = cell_x_i;
  assign cidx[1] = cell_y_i;
  assign cidx[2] = cell_z_i;

  assign cfg_ready_o = 1'b1;

  vro_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  vro_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .lis_i            (lis),
    .src_i            (src),
    .cell_i           (cidx),
    .cell_solid_i     (cell_solid_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i       (cfg_data_i),
    .done_o           (done_o),
    .occlusion_o      (occlusion_o),
    .solid_count_o    (solid_count_o),
    .reached_source_o (reached_source_o)
  );

endmodule

// ----- sv/vro_checker.sv -----
// ----------------------------------------------------------------------------
// vro_checker
// port-level checks on query handshake, result strobe and occlusion value range
// ----------------------------------------------------------------------------
module vro_checker import vro_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             kind_i,
  input logic             done_o,
  input logic [OCC_W-1:0] occlusion_o,
  input logic [CNT_W-1:0] solid_count_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while busy");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> occlusion_o <= OCC_W'(256)) else $error("occlusion above saturation");

  a_occ_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && solid_count_o == '0 |-> occlusion_o == '0) else $error("occlusion without solids");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i |=> busy_o) else $error("query not taken");

endmodule

bind voxel_ray_occlusion_unit vro_checker u_vro_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .kind_i        (kind_i),
  .done_o        (done_o),
  .occlusion_o   (occlusion_o),
  .solid_count_o (solid_count_o)
);

// ----- dv/tb_voxel_ray_occlusion_unit.sv -----
// ----------------------------------------------------------------------------
// tb_voxel_ray_occlusion_unit
// self-checking testbench: map writes and occlusion queries against a dda
// predictor, over several register settings, with random bursts and gaps
// ----------------------------------------------------------------------------
module tb_voxel_ray_occlusion_unit;
  import vro_pkg::*;

  typedef struct {
    logic              kind;
    logic [POS_W-1:0]  lis [3];
    logic [POS_W-1:0]  src [3];
    logic [CELL_W-1:0] cidx [3];
    logic              solid;
  } item_t;

  typedef struct {
    logic [OCC_W-1:0] occ;
    logic [CNT_W-1:0] cnt;
    logic             reached;
  } answer_t;

  localparam int WATCHDOG_LIMIT = 150000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              kind_i = 1'b0;
  logic [POS_W-1:0]  listener_x_i = '0, listener_y_i = '0, listener_z_i = '0;
  logic [POS_W-1:0]  source_x_i = '0, source_y_i = '0, source_z_i = '0;
  logic [CELL_W-1:0] cell_x_i = '0, cell_y_i = '0, cell_z_i = '0;
  logic              cell_solid_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [15:0]       cfg_data_i = '0;
  logic              done_o;
  logic [OCC_W-1:0]  occlusion_o;
  logic [CNT_W-1:0]  solid_count_o;
  logic              reached_source_o;

  voxel_ray_occlusion_unit u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  item_t   pending_items[$];
  answer_t expected_answers[$];
  bit      occ_map [CELL_CNT];
  int      mismatches = 0;
  int      idle_cycles = 0;

  // register copies
  logic [7:0]  max_steps_q = 8'd64;
  logic [8:0]  per_block_q = 9'd87;
  logic [15:0] min_dist_q = '0;
  logic        occ_en_q = 1'b1;

  function automatic bit solid_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GRID_SIZE || y >= GRID_SIZE || z >= GRID_SIZE)
      return 1'b0;
    return occ_map[(z * GRID_SIZE + y) * GRID_SIZE + x];
  endfunction

  function automatic answer_t walk_ray(item_t it);
    answer_t a;
    longint unsigned dsq, tmax[3], tdel[3], bnd, ad, one;
    longint d;
    int cur[3], fin[3], stp[3], count, ax;
    one = longint'(1) << FRAC_BITS;
    dsq = 0;
    count = 0;
    a.occ = '0;
    a.cnt = '0;
    a.reached = 1'b1;
    for (int k = 0; k < 3; k++) begin
      d = longint'(it.src[k]) - longint'(it.lis[k]);
      dsq += longint'(d * d);
    end
    if (!occ_en_q || dsq < longint'(min_dist_q)) return a;
    for (int k = 0; k < 3; k++) begin
      cur[k] = it.lis[k] >> FRAC_BITS;
      fin[k] = it.src[k] >> FRAC_BITS;
      if (it.src[k] == it.lis[k]) begin
        stp[k] = 0;
        tmax[k] = '1;
        tdel[k] = '1;
      end else begin
        if (it.src[k] > it.lis[k]) begin
          stp[k] = 1;
          ad = it.src[k] - it.lis[k];
          bnd = one - (it.lis[k] & (one - 1));
        end else begin
          stp[k] = -1;
          ad = it.lis[k] - it.src[k];
          bnd = it.lis[k] & (one - 1);
        end
        tmax[k] = (bnd << 16) / ad;
        tdel[k] = (one << 16) / ad;
      end
    end
    for (int n = 0; n < max_steps_q; n++) begin
      if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) break;
      if (tmax[0] <= tmax[1] && tmax[0] <= tmax[2]) ax = 0;
      else if (tmax[1] <= tmax[2]) ax = 1;
      else ax = 2;
      if (stp[ax] != 0) begin
        cur[ax] += stp[ax];
        tmax[ax] += tdel[ax];
      end
      if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) break;
      if (solid_at(cur[0], cur[1], cur[2])) count++;
    end
    a.occ = (count * per_block_q > 256) ? 9'd256 : OCC_W'(count * per_block_q);
    a.cnt = CNT_W'(count);
    a.reached = (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]);
    return a;
  endfunction

  // driver
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    logic nxt_start;
    item_t it;
    nxt_start = start_i;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        void'(pending_items.pop_front());
        if (burst_left > 0) burst_left--;
        nxt_start = 1'b0;
      end
      if (!(start_i && busy_o)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
        if (gap_left > 0) begin
          gap_left--;
          nxt_start = 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items[0];
          kind_i <= it.kind;
          listener_x_i <= it.lis[0];
          listener_y_i <= it.lis[1];
          listener_z_i <= it.lis[2];
          source_x_i <= it.src[0];
          source_y_i <= it.src[1];
          source_z_i <= it.src[2];
          cell_x_i <= it.cidx[0];
          cell_y_i <= it.cidx[1];
          cell_z_i <= it.cidx[2];
          cell_solid_i <= it.solid;
          nxt_start = 1'b1;
        end
      end
    end
    start_i <= nxt_start;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    item_t it;
    answer_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MAX_STEPS:   max_steps_q <= cfg_data_i[7:0];
          REG_PER_BLOCK:   per_block_q <= cfg_data_i[8:0];
          REG_MIN_DIST_SQ: min_dist_q  <= cfg_data_i;
          REG_OCC_EN:      occ_en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        it.kind = kind_i;
        it.lis = '{listener_x_i, listener_y_i, listener_z_i};
        it.src = '{source_x_i, source_y_i, source_z_i};
        it.cidx = '{cell_x_i, cell_y_i, cell_z_i};
        it.solid = cell_solid_i;
        if (!it.kind)
          occ_map[(int'(cell_z_i) * GRID_SIZE + cell_y_i) * GRID_SIZE + cell_x_i] = cell_solid_i;
        else
          expected_answers.push_back(walk_ray(it));
      end
      if (done_o) begin
        got = '{occlusion_o, solid_count_o, reached_source_o};
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result occ=%0d cnt=%0d reached=%0b",
                                         got.occ, got.cnt, got.reached);
        end else begin
          want = expected_answers.pop_front();
          if (got.occ !== want.occ || got.cnt !== want.cnt || got.reached !== want.reached) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected occ=%0d cnt=%0d reached=%0b, got occ=%0d cnt=%0d reached=%0b",
                       want.occ, want.cnt, want.reached, got.occ, got.cnt, got.reached);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [POS_W-1:0] rand_pos(int lo, int hi);
    logic [7:0] frac;
    case ($urandom_range(0, 3))
      0: frac = 8'd0;
      1: frac = 8'd255;
      default: frac = 8'($urandom_range(0, 255));
    endcase
    return {5'($urandom_range(lo, hi)), frac};
  endfunction

  function automatic item_t cell_write(int x, int y, int z, bit s);
    item_t it;
    it.kind = 1'b0;
    it.lis = '{13'($urandom), 13'($urandom), 13'($urandom)};
    it.src = '{13'($urandom), 13'($urandom), 13'($urandom)};
    it.cidx = '{5'(x), 5'(y), 5'(z)};
    it.solid = s;
    return it;
  endfunction

  function automatic item_t ray_query(int lx, int ly, int lz, int sx, int sy, int sz);
    item_t it;
    it.kind = 1'b1;
    it.lis = '{13'(lx), 13'(ly), 13'(lz)};
    it.src = '{13'(sx), 13'(sy), 13'(sz)};
    it.cidx = '{5'($urandom), 5'($urandom), 5'($urandom)};
    it.solid = 1'($urandom);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int lo, hi;
    if ($urandom_range(0, 9) < 4) begin
      lo = ($urandom_range(0, 4) == 0) ? 0 : 8;
      hi = (lo == 0) ? 31 : 15;
      return cell_write($urandom_range(lo, hi), $urandom_range(lo, hi),
                        $urandom_range(lo, hi), $urandom_range(0, 9) < 7);
    end
    it = ray_query(0, 0, 0, 0, 0, 0);
    if ($urandom_range(0, 9) == 0) begin
      for (int k = 0; k < 3; k++) begin
        it.lis[k] = 13'($urandom_range(0, 8191));
        it.src[k] = 13'($urandom_range(0, 8191));
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        it.lis[k] = rand_pos(6, 17);
        it.src[k] = rand_pos(6, 17);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if ($urandom_range(0, 7) == 0) it.src[k] = it.lis[k];
      else if ($urandom_range(0, 9) == 0) it.src[k][12:8] = it.lis[k][12:8];
    end
    return it;
  endfunction

  task automatic write_reg(cfg_reg_e r, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_items.size() > 0 || expected_answers.size() > 0 || busy_o || start_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: walls, extremes and special cases at reset settings
    for (int i = 0; i < 5; i++) pending_items.push_back(cell_write(10 + i, 10, 10, 1'b1));
    pending_items.push_back(cell_write(0, 0, 0, 1'b1));
    pending_items.push_back(cell_write(31, 31, 31, 1'b1));
    pending_items.push_back(cell_write(12, 10, 10, 1'b0));
    pending_items.push_back(ray_query(9 << 8, 10 << 8 | 128, 10 << 8 | 128,
                                      16 << 8 | 10, 10 << 8 | 128, 10 << 8 | 128));
    pending_items.push_back(ray_query(16 << 8, 10 << 8, 10 << 8, 9 << 8 | 255, 10 << 8, 10 << 8));
    pending_items.push_back(ray_query(0, 0, 0, 8191, 8191, 8191));
    pending_items.push_back(ray_query(8191, 8191, 8191, 0, 0, 0));
    pending_items.push_back(ray_query(8191, 0, 8191, 0, 8191, 0));
    pending_items.push_back(ray_query(1000, 1000, 1000, 1000, 1000, 1000));
    pending_items.push_back(ray_query(10 << 8 | 3, 5 << 8, 7 << 8, 10 << 8 | 200, 5 << 8 | 9, 7 << 8));
    pending_items.push_back(ray_query(9 << 8, 9 << 8, 9 << 8, 15 << 8, 11 << 8, 11 << 8));
    pending_items.push_back(ray_query(10 << 8, 10 << 8, 10 << 8, 11 << 8, 11 << 8, 11 << 8));
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin write_reg(REG_MAX_STEPS, 16'd255); write_reg(REG_PER_BLOCK, 16'd256); end
        1: write_reg(REG_MAX_STEPS, 16'd0);
        2: begin write_reg(REG_MAX_STEPS, 16'd64); write_reg(REG_PER_BLOCK, 16'd0); end
        3: begin write_reg(REG_OCC_EN, 16'd0); write_reg(REG_PER_BLOCK, 16'd511); end
        4: begin write_reg(REG_OCC_EN, 16'd1); write_reg(REG_MIN_DIST_SQ, 16'hFFFF); end
        5: begin write_reg(REG_MIN_DIST_SQ, 16'd0); write_reg(REG_PER_BLOCK, 16'd87);
                 write_reg(REG_MAX_STEPS, 16'd3); end
        default: begin
          write_reg(REG_MAX_STEPS, 16'($urandom_range(0, 255)));
          write_reg(REG_PER_BLOCK, 16'($urandom_range(0, 511)));
          write_reg(REG_MIN_DIST_SQ, ($urandom_range(0, 1)) ? 16'($urandom) : 16'd0);
          write_reg(REG_OCC_EN, 16'($urandom_range(0, 4) != 0));
        end
      endcase
      if (p == 1) begin
        pending_items.push_back(ray_query(5 << 8, 5 << 8, 5 << 8, 5 << 8 | 9, 5 << 8, 5 << 8));
        pending_items.push_back(ray_query(5 << 8, 5 << 8, 5 << 8, 6 << 8, 5 << 8, 5 << 8));
      end
      for (int i = 0; i < 59; i++) pending_items.push_back(random_item());
      drain();
    end

    if (expected_answers.size() == 0 && mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
